@@ hdl/lvs3_pkg.sv @@
// ----------------------------------------------------------------------------
// lvs3_pkg: shared definitions for the 3D line voxel stepper
// Widths, limits, axis codes and the minor-axis rounding helper.
// ----------------------------------------------------------------------------
package lvs3_pkg;

  localparam int CoordBits = 26;
  localparam int MaxSpan   = 63;
  localparam int SpanW     = $clog2(MaxSpan + 1);
  localparam int InDataW   = ((6 * CoordBits + 7) / 8) * 8;
  localparam int OutDataW  = ((3 * CoordBits + 7) / 8) * 8;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic        [CoordBits-1:0] mag_t;
  typedef logic        [SpanW-1:0]     span_t;
  typedef logic        [1:0]           axis_t;

  localparam axis_t AxisX = 2'd0;
  localparam axis_t AxisY = 2'd1;
  localparam axis_t AxisZ = 2'd2;

  // Rounds base + sign * (r / span) half away from zero on the result.
  function automatic coord_t round_minor(coord_t c, logic neg, span_t r, span_t span);
    logic [SpanW:0] twice_r;
    logic           up;
    logic           down;
    twice_r = {r, 1'b0};
    up      = 1'b0;
    down    = 1'b0;
    if (r != '0) begin
      if (twice_r > {1'b0, span}) begin
        up   = !neg;
        down = neg;
      end else if (twice_r == {1'b0, span}) begin
        if (!neg) begin
          up = !c[CoordBits-1];
        end else begin
          down = c[CoordBits-1] || (c == '0);
        end
      end
    end
    if (up) begin
      return c + coord_t'(1);
    end else if (down) begin
      return c - coord_t'(1);
    end
    return c;
  endfunction

endpackage

@@ hdl/line_voxel_stepper_3d.sv @@
// ----------------------------------------------------------------------------
// line_voxel_stepper_3d: 3D line voxelizer
// Takes two integer endpoints and streams out every voxel of the line.
// ----------------------------------------------------------------------------
// A line word is taken only while the block is idle. One shared subtractor
// then forms the span of each axis, one axis per cycle, and a select cycle
// picks the dominant axis. After that one voxel word is produced per cycle
// while the output is free. A line whose dominant span exceeds 63 yields a
// single word with the start point and tuser set. The output register lets
// the next line be accepted while the final voxel still waits to be taken.
module line_voxel_stepper_3d (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, zero fill
  input  logic [lvs3_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // point_x, point_y, point_z, zero fill
  output logic [lvs3_pkg::OutDataW-1:0]  m_axis_tdata,
  // last_point
  output logic                           m_axis_tlast,
  // too_long
  output logic                           m_axis_tuser
);

  localparam int Cb = lvs3_pkg::CoordBits;

  typedef enum logic [1:0] {
    StIdle,
    StDiff,
    StSelect,
    StEmit
  } state_e;

  state_e              state_q;
  lvs3_pkg::coord_t    a_q [3];
  lvs3_pkg::coord_t    b_q [3];
  lvs3_pkg::mag_t      d_q [3];
  logic [2:0]          neg_q;
  lvs3_pkg::axis_t     ax_q;
  lvs3_pkg::axis_t     mj_q;
  lvs3_pkg::coord_t    maj_q;
  lvs3_pkg::coord_t    c1_q;
  lvs3_pkg::coord_t    c2_q;
  lvs3_pkg::span_t     r1_q;
  lvs3_pkg::span_t     r2_q;
  lvs3_pkg::span_t     dm1_q;
  lvs3_pkg::span_t     dm2_q;
  lvs3_pkg::span_t     span_q;
  lvs3_pkg::span_t     steps_q;
  logic                negmaj_q;
  logic                neg1_q;
  logic                neg2_q;
  logic                out_valid_q;
  logic                out_valid_d;
  lvs3_pkg::coord_t    out_pt_q [3];
  logic                out_last_q;
  logic                out_long_q;

  logic signed [Cb:0]  diff;
  logic signed [Cb:0]  diff_abs;
  lvs3_pkg::axis_t     mj_sel;
  lvs3_pkg::axis_t     m1_sel;
  lvs3_pkg::axis_t     m2_sel;
  lvs3_pkg::mag_t      span_sel;
  logic                out_free;
  lvs3_pkg::coord_t    rnd1;
  lvs3_pkg::coord_t    rnd2;
  logic [lvs3_pkg::SpanW:0] sum1;
  logic [lvs3_pkg::SpanW:0] sum2;
  logic                wrap1;
  logic                wrap2;

  // Shared subtractor: span and direction of the axis under ax_q.
  always_comb begin
    diff     = $signed({b_q[ax_q][Cb-1], b_q[ax_q]}) - $signed({a_q[ax_q][Cb-1], a_q[ax_q]});
    diff_abs = diff[Cb] ? -diff : diff;
  end

  always_comb begin
    if (d_q[0] >= d_q[1] && d_q[0] >= d_q[2]) begin
      mj_sel = lvs3_pkg::AxisX;
    end else if (d_q[1] >= d_q[2]) begin
      mj_sel = lvs3_pkg::AxisY;
    end else begin
      mj_sel = lvs3_pkg::AxisZ;
    end
    m1_sel = (mj_sel == lvs3_pkg::AxisX) ? lvs3_pkg::AxisY : lvs3_pkg::AxisX;
    m2_sel = (mj_sel == lvs3_pkg::AxisZ) ? lvs3_pkg::AxisY : lvs3_pkg::AxisZ;
    span_sel = d_q[mj_sel];
  end

  always_comb begin
    out_free    = !out_valid_q || m_axis_tready;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (out_free) begin
      if (state_q == StEmit || (state_q == StSelect &&
          span_sel > lvs3_pkg::mag_t'(lvs3_pkg::MaxSpan))) begin
        out_valid_d = 1'b1;
      end
    end
    rnd1     = lvs3_pkg::round_minor(c1_q, neg1_q, r1_q, span_q);
    rnd2     = lvs3_pkg::round_minor(c2_q, neg2_q, r2_q, span_q);
    sum1     = {1'b0, r1_q} + {1'b0, dm1_q};
    sum2     = {1'b0, r2_q} + {1'b0, dm2_q};
    wrap1    = sum1 >= {1'b0, span_q};
    wrap2    = sum2 >= {1'b0, span_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_long_q  <= 1'b0;
      ax_q        <= lvs3_pkg::AxisX;
      mj_q        <= lvs3_pkg::AxisX;
      steps_q     <= '0;
      for (int i = 0; i < 3; i++) begin
        a_q[i]      <= '0;
        b_q[i]      <= '0;
        d_q[i]      <= '0;
        out_pt_q[i] <= '0;
      end
      neg_q       <= '0;
      maj_q       <= '0;
      c1_q        <= '0;
      c2_q        <= '0;
      r1_q        <= '0;
      r2_q        <= '0;
      dm1_q       <= '0;
      dm2_q       <= '0;
      span_q      <= '0;
      negmaj_q    <= 1'b0;
      neg1_q      <= 1'b0;
      neg2_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            for (int i = 0; i < 3; i++) begin
              a_q[i] <= s_axis_tdata[i*Cb +: Cb];
              b_q[i] <= s_axis_tdata[(i+3)*Cb +: Cb];
            end
            ax_q    <= lvs3_pkg::AxisX;
            state_q <= StDiff;
          end
        end
        StDiff: begin
          d_q[ax_q]   <= diff_abs[Cb-1:0];
          neg_q[ax_q] <= diff[Cb];
          if (ax_q == lvs3_pkg::AxisZ) begin
            state_q <= StSelect;
          end else begin
            ax_q <= ax_q + lvs3_pkg::axis_t'(1);
          end
        end
        StSelect: begin
          if (span_sel > lvs3_pkg::mag_t'(lvs3_pkg::MaxSpan)) begin
            if (out_free) begin
              for (int i = 0; i < 3; i++) begin
                out_pt_q[i] <= a_q[i];
              end
              out_last_q <= 1'b1;
              out_long_q <= 1'b1;
              state_q    <= StIdle;
            end
          end else begin
            mj_q     <= mj_sel;
            maj_q    <= a_q[mj_sel];
            c1_q     <= a_q[m1_sel];
            c2_q     <= a_q[m2_sel];
            negmaj_q <= neg_q[mj_sel];
            neg1_q   <= neg_q[m1_sel];
            neg2_q   <= neg_q[m2_sel];
            dm1_q    <= d_q[m1_sel][lvs3_pkg::SpanW-1:0];
            dm2_q    <= d_q[m2_sel][lvs3_pkg::SpanW-1:0];
            span_q   <= span_sel[lvs3_pkg::SpanW-1:0];
            steps_q  <= span_sel[lvs3_pkg::SpanW-1:0];
            r1_q     <= '0;
            r2_q     <= '0;
            state_q  <= StEmit;
          end
        end
        StEmit: begin
          if (out_free) begin
            out_last_q  <= (steps_q == '0);
            out_long_q  <= 1'b0;
            unique case (mj_q)
              lvs3_pkg::AxisX: begin
                out_pt_q[0] <= maj_q;
                out_pt_q[1] <= rnd1;
                out_pt_q[2] <= rnd2;
              end
              lvs3_pkg::AxisY: begin
                out_pt_q[0] <= rnd1;
                out_pt_q[1] <= maj_q;
                out_pt_q[2] <= rnd2;
              end
              default: begin
                out_pt_q[0] <= rnd1;
                out_pt_q[1] <= rnd2;
                out_pt_q[2] <= maj_q;
              end
            endcase
            maj_q <= negmaj_q ? maj_q - lvs3_pkg::coord_t'(1)
                              : maj_q + lvs3_pkg::coord_t'(1);
            if (wrap1) begin
              r1_q <= lvs3_pkg::span_t'(sum1 - {1'b0, span_q});
              c1_q <= neg1_q ? c1_q - lvs3_pkg::coord_t'(1) : c1_q + lvs3_pkg::coord_t'(1);
            end else begin
              r1_q <= sum1[lvs3_pkg::SpanW-1:0];
            end
            if (wrap2) begin
              r2_q <= lvs3_pkg::span_t'(sum2 - {1'b0, span_q});
              c2_q <= neg2_q ? c2_q - lvs3_pkg::coord_t'(1) : c2_q + lvs3_pkg::coord_t'(1);
            end else begin
              r2_q <= sum2[lvs3_pkg::SpanW-1:0];
            end
            if (steps_q == '0) begin
              state_q <= StIdle;
            end else begin
              steps_q <= steps_q - lvs3_pkg::span_t'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(lvs3_pkg::OutDataW - 3 * Cb){1'b0}},
                          out_pt_q[2], out_pt_q[1], out_pt_q[0]};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_long_q;

endmodule
